/* hdl/esc_tlm_pkg.sv */
// Shared constants and CRC-8 helper for the ESC telemetry frame receiver.
package esc_tlm_pkg;

   localparam int unsigned PayloadLen = 9;
   localparam int unsigned PosWidth   = 4;
   localparam logic [7:0]  CrcPoly    = 8'h07;
   localparam logic [7:0]  CrcMsb     = 8'h80;

   typedef logic [PosWidth-1:0] pos_type;
   typedef logic [7:0]          byte_type;

   // CRC-8, MSB first, one data byte folded in
   function automatic byte_type crc_fold(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CrcMsb) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/esc_telemetry_frame_receiver.sv */
// Top level: ESC telemetry frame receiver with CRC-8 check and field decode.
//
// Accepts a fixed 10-byte telemetry frame, one UART byte per cycle while not
// stalled. Bytes 0..8 are captured and folded into a CRC-8 (poly 0x07, init
// 0, MSB first); byte 9 is compared with that CRC and yields one result item
// with rsp_crc_good and the decoded big-endian fields (fields read zero when
// the CRC fails). The CRC update is a single 8-step fold between the state
// registers. The result waits in an output register; payload bytes keep
// flowing while it waits, and only a check byte stalls until the previous
// result has been taken.
module esc_telemetry_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_crc_good,
   output logic [7:0]  rsp_temperature,
   output logic [15:0] rsp_voltage,
   output logic [15:0] rsp_current,
   output logic [15:0] rsp_consumption,
   output logic [15:0] rsp_erpm
);

   esc_tlm_pkg::pos_type  pos_ff, pos_in;
   esc_tlm_pkg::byte_type crc_ff, crc_in;
   esc_tlm_pkg::byte_type payload_ff [esc_tlm_pkg::PayloadLen];

   logic        rsp_valid_ff, rsp_valid_in;
   logic        good_ff, good_in;
   logic [7:0]  temp_ff, temp_in;
   logic [15:0] volt_ff, volt_in;
   logic [15:0] curr_ff, curr_in;
   logic [15:0] cons_ff, cons_in;
   logic [15:0] erpm_ff, erpm_in;

   logic is_check;
   logic accept;
   logic match;

   assign is_check  = (pos_ff >= esc_tlm_pkg::pos_type'(esc_tlm_pkg::PayloadLen));
   assign req_ready = !is_check || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign match     = (crc_ff == req_rx_byte);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      good_in      = good_ff;
      temp_in      = temp_ff;
      volt_in      = volt_ff;
      curr_in      = curr_ff;
      cons_in      = cons_ff;
      erpm_in      = erpm_ff;
      if (accept) begin
         if (!is_check) begin
            pos_in = pos_ff + esc_tlm_pkg::pos_type'(1);
            crc_in = esc_tlm_pkg::crc_fold(crc_ff, req_rx_byte);
         end else begin
            pos_in       = '0;
            crc_in       = '0;
            rsp_valid_in = 1'b1;
            good_in      = match;
            temp_in      = match ? payload_ff[0] : 8'h00;
            volt_in      = match ? {payload_ff[1], payload_ff[2]} : 16'h0000;
            curr_in      = match ? {payload_ff[3], payload_ff[4]} : 16'h0000;
            cons_in      = match ? {payload_ff[5], payload_ff[6]} : 16'h0000;
            erpm_in      = match ? {payload_ff[7], payload_ff[8]} : 16'h0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      good_ff <= good_in;
      temp_ff <= temp_in;
      volt_ff <= volt_in;
      curr_ff <= curr_in;
      cons_ff <= cons_in;
      erpm_ff <= erpm_in;
   end

   // payload capture, one fixed register per payload position
   for (genvar i = 0; i < esc_tlm_pkg::PayloadLen; i++) begin : g_payload
      always_ff @(posedge clock) begin
         if (accept && (pos_ff == esc_tlm_pkg::pos_type'(i))) begin
            payload_ff[i] <= req_rx_byte;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_crc_good    = good_ff;
   assign rsp_temperature = temp_ff;
   assign rsp_voltage     = volt_ff;
   assign rsp_current     = curr_ff;
   assign rsp_consumption = cons_ff;
   assign rsp_erpm        = erpm_ff;

endmodule
